@@ hw/rtl/sjd_pkg.sv @@
// ----------------------------------------------------------------------------
// sjd_pkg: shared types and constants for the spectral jitter detector.
// Holds the sequencer state type, the configuration register indexes, the
// status codes and the sine polynomial coefficients.
// ----------------------------------------------------------------------------
package sjd_pkg;

    // Configuration port geometry.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_BIN    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEGREE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEIGHT = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_REJECT   = 2'd0;
    localparam logic [1:0] STATUS_FILLING  = 2'd1;
    localparam logic [1:0] STATUS_SPECTRUM = 2'd2;

    // Register reset values.
    localparam logic [30:0] STEP_LIMIT_RST = 31'd65536;

    // Saturation bound of the band sum.
    localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;

    // Quarter-wave sine polynomial in Q30 (odd terms, degree 9).
    localparam logic [63:0] Q30_ONE = 64'd1073741824;
    localparam logic [63:0] PA1     = 64'd1686629713;
    localparam logic [63:0] PA3     = 64'd693598668;
    localparam logic [63:0] PA5     = 64'd85569306;
    localparam logic [63:0] PA7     = 64'd5026993;
    localparam logic [63:0] PA9     = 64'd172272;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MAC,
        ST_SHIFT,
        ST_SQ_A,
        ST_SQ_B,
        ST_SQRT,
        ST_ACC,
        ST_EMA,
        ST_EMA_FIN,
        ST_DONE
    } t_state;

endpackage

@@ hw/rtl/spectral_jitter_detector.sv @@
// A rejected or window-filling sample gives its result in the cycle after acceptance. A spectrum
// sample runs bin by bin from start_bin up to N/2 - 1, each bin through the DFT multiply pair, the
// normalizing shift and the bit-serial square root; an empty band goes straight to the EMA, and the
// first spectrum loads the EMA without smoothing. One new sample is accepted at a time. Synchronous
// active-low reset clears the window count, the EMA, start bin, degree limit and last height; the
// step limit returns to its reset value.
// ----------------------------------------------------------------------------
// spectral_jitter_detector
// Height step filter with a sliding window of step sizes, band magnitude of
// the window's DFT formed by a sequenced multiply pair and an iterative square
// root, smoothed by an exponential moving average and compared to a limit.
// ----------------------------------------------------------------------------
module spectral_jitter_detector
    import sjd_pkg::*;
#(
    parameter int WINDOW_SIZE = 32,
    parameter int EMA_LENGTH  = 7
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wr_data,
    // Input channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_height,
    // Output channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_valid_res,
    output logic [1:0]            o_status,
    output logic [47:0]           o_degree
);

    localparam int NW   = $clog2(WINDOW_SIZE);
    localparam int FW   = $clog2(WINDOW_SIZE + 1);
    localparam int HALF = WINDOW_SIZE / 2;
    localparam logic [16:0] EMA_W  = 17'((131072 + (EMA_LENGTH + 1) / 2) / (EMA_LENGTH + 1));
    localparam logic [16:0] EMA_WC = 17'(65536 - ((131072 + (EMA_LENGTH + 1) / 2)
                                                  / (EMA_LENGTH + 1)));

    // ------------------------------------------------------------------------
    // Twiddle tables, built at elaboration.
    // ------------------------------------------------------------------------
    function automatic logic [63:0] quarter_sin(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x2 = (x * x) >> 30;
        t  = PA9;
        t  = PA7 - ((x2 * t) >> 30);
        t  = PA5 - ((x2 * t) >> 30);
        t  = PA3 - ((x2 * t) >> 30);
        t  = PA1 - ((x2 * t) >> 30);
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s;
    endfunction

    function automatic logic [WINDOW_SIZE*16-1:0] tw_table(input logic cos_sel);
        logic [WINDOW_SIZE*16-1:0] tab;
        logic [63:0] x;
        logic [63:0] qs;
        logic [15:0] sv;
        logic [15:0] cv;
        logic [15:0] sn;
        logic [15:0] cs;
        int u;
        int q;
        int rem;
        tab = '0;
        for (int i = 0; i < WINDOW_SIZE; i++) begin
            u   = 4 * i;
            q   = u / WINDOW_SIZE;
            rem = u % WINDOW_SIZE;
            x   = (64'(rem) << 30) / WINDOW_SIZE;
            qs  = quarter_sin(x);
            sv  = qs[15:0];
            qs  = quarter_sin(Q30_ONE - x);
            cv  = qs[15:0];
            case (q & 3)
                0:       begin sn = sv;  cs = cv;  end
                1:       begin sn = cv;  cs = -sv; end
                2:       begin sn = -sv; cs = -cv; end
                default: begin sn = -cv; cs = sv;  end
            endcase
            tab[i*16 +: 16] = cos_sel ? cs : sn;
        end
        return tab;
    endfunction

    localparam logic [WINDOW_SIZE*16-1:0] COS_TAB = tw_table(1'b1);
    localparam logic [WINDOW_SIZE*16-1:0] SIN_TAB = tw_table(1'b0);

    // ------------------------------------------------------------------------
    // Registers.
    // ------------------------------------------------------------------------
    t_state r_state, n_state;

    logic [4:0]         r_start_bin;
    logic [47:0]        r_degree_limit;
    logic [30:0]        r_step_limit;
    logic signed [31:0] r_last_height;

    logic [30:0]        r_window [WINDOW_SIZE];
    logic [FW-1:0]      r_fill;
    logic [NW-1:0]      r_wptr;
    logic [47:0]        r_ema;
    logic               r_ema_started;

    logic [NW-1:0]      r_k;
    logic [FW-1:0]      r_n;
    logic [NW-1:0]      r_rd_ptr;
    logic [NW-1:0]      r_idx;
    logic               r_p1_vld;
    logic [30:0]        r_rdata;
    logic [NW-1:0]      r_p1_idx;
    logic               r_p2_vld;
    logic signed [51:0] r_pc;
    logic signed [51:0] r_ps;
    logic signed [63:0] r_re;
    logic signed [63:0] r_im;

    logic [63:0]        r_a;
    logic [63:0]        r_b;
    logic [5:0]         r_shift;
    logic [63:0]        r_v;
    logic [63:0]        r_res;
    logic [63:0]        r_bit;
    logic [4:0]         r_sq_cnt;
    logic [47:0]        r_total;
    logic [1:0]         r_ema_step;
    logic [65:0]        r_ema_acc;

    logic               r_out_vld;
    logic               r_out_valid_res;
    logic [1:0]         r_out_status;
    logic [47:0]        r_out_degree;

    // ------------------------------------------------------------------------
    // Step check on the incoming sample.
    // ------------------------------------------------------------------------
    logic signed [32:0] diff;
    logic [32:0]        abs_diff;
    logic               step_reject;
    logic               win_full;
    logic               band_empty;
    logic [NW-1:0]      wptr_inc;

    always_comb begin
        diff        = {i_height[31], i_height} - {r_last_height[31], r_last_height};
        abs_diff    = diff[32] ? 33'(-diff) : 33'(diff);
        step_reject = abs_diff > {2'b00, r_step_limit};
        win_full    = r_fill == FW'(WINDOW_SIZE);
        band_empty  = 32'(r_start_bin) >= 32'(HALF);
        wptr_inc    = (r_wptr == NW'(WINDOW_SIZE - 1)) ? '0 : r_wptr + 1'b1;
    end

    // ------------------------------------------------------------------------
    // Control decode: handshakes and bin start strobes.
    // ------------------------------------------------------------------------
    logic in_acc;
    logic out_free;
    logic mac_init;
    logic mac_done;
    logic shift_done;
    logic last_bin;
    logic out_take;

    always_comb begin
        out_take   = r_out_vld && !i_stall;
        out_free   = !r_out_vld || !i_stall;
        o_stall    = (r_state != ST_IDLE) || !out_free;
        in_acc     = i_valid && !o_stall;
        last_bin   = r_k == NW'(HALF - 1);
        mac_done   = (r_n == FW'(WINDOW_SIZE)) && !r_p1_vld && !r_p2_vld;
        shift_done = (r_a[63:31] == '0) && (r_b[63:31] == '0);
        mac_init   = ((r_state == ST_IDLE) && in_acc && !step_reject && win_full
                      && !band_empty)
                     || ((r_state == ST_ACC) && !last_bin);
    end

    // ------------------------------------------------------------------------
    // Next state.
    // ------------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && !step_reject && win_full) begin
                    n_state = band_empty ? ST_EMA : ST_MAC;
                end
            end
            ST_MAC: begin
                if (mac_done) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                if (shift_done) begin
                    n_state = ST_SQ_A;
                end
            end
            ST_SQ_A: n_state = ST_SQ_B;
            ST_SQ_B: n_state = ST_SQRT;
            ST_SQRT: begin
                if (r_sq_cnt == 5'd31) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: n_state = last_bin ? ST_EMA : ST_MAC;
            ST_EMA: begin
                if (!r_ema_started) begin
                    n_state = ST_DONE;
                end else if (r_ema_step == 2'd3) begin
                    n_state = ST_EMA_FIN;
                end
            end
            ST_EMA_FIN: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration registers and last accepted height.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_bin    <= '0;
            r_degree_limit <= '0;
            r_step_limit   <= STEP_LIMIT_RST;
            r_last_height  <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_START_BIN:    r_start_bin    <= i_cfg_wr_data[4:0];
                    CFG_DEGREE_LIMIT: r_degree_limit <= i_cfg_wr_data[47:0];
                    CFG_STEP_LIMIT:   r_step_limit   <= i_cfg_wr_data[30:0];
                    CFG_START_HEIGHT: r_last_height  <= $signed(i_cfg_wr_data[31:0]);
                    default: ;
                endcase
            end else if (in_acc && !step_reject) begin
                r_last_height <= i_height;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Difference window: circular memory, oldest entry at the write pointer.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_acc && !step_reject) begin
            r_window[r_wptr] <= abs_diff[30:0];
        end
        r_rdata <= r_window[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_wptr <= '0;
        end else if (in_acc && !step_reject) begin
            r_wptr <= wptr_inc;
            if (!win_full) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // DFT bin: read, multiply pair, accumulate, one sample a cycle.
    // ------------------------------------------------------------------------
    logic [NW:0]        idx_sum;
    logic [34:0]        d10;
    logic signed [15:0] tw_cos;
    logic signed [15:0] tw_sin;

    always_comb begin
        idx_sum = {1'b0, r_idx} + {1'b0, r_k};
        d10     = ({4'b0, r_rdata} << 3) + ({4'b0, r_rdata} << 1);
        tw_cos  = $signed(COS_TAB[r_p1_idx*16 +: 16]);
        tw_sin  = $signed(SIN_TAB[r_p1_idx*16 +: 16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_n      <= '0;
            r_k      <= '0;
        end else begin
            r_p1_vld <= (r_state == ST_MAC) && (r_n != FW'(WINDOW_SIZE));
            r_p2_vld <= r_p1_vld;
            if (mac_init) begin
                r_n      <= '0;
                r_idx    <= '0;
                r_rd_ptr <= (r_state == ST_IDLE) ? wptr_inc : r_wptr;
                r_k      <= (r_state == ST_IDLE) ? NW'(r_start_bin) : r_k + 1'b1;
                r_re     <= '0;
                r_im     <= '0;
            end else if (r_state == ST_MAC) begin
                if (r_n != FW'(WINDOW_SIZE)) begin
                    r_p1_idx <= r_idx;
                    r_n      <= r_n + 1'b1;
                    r_rd_ptr <= (r_rd_ptr == NW'(WINDOW_SIZE - 1)) ? '0 : r_rd_ptr + 1'b1;
                    r_idx    <= (idx_sum >= (NW+1)'(WINDOW_SIZE))
                                ? NW'(idx_sum - (NW+1)'(WINDOW_SIZE)) : NW'(idx_sum);
                end
                if (r_p2_vld) begin
                    r_re <= r_re + 64'(r_pc);
                    r_im <= r_im - 64'(r_ps);
                end
            end
            if (r_p1_vld) begin
                r_pc <= $signed({1'b0, d10}) * tw_cos;
                r_ps <= $signed({1'b0, d10}) * tw_sin;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Bin magnitude: normalize, square, bit-serial root, band sum.
    // ------------------------------------------------------------------------
    logic [30:0] sq_op;
    logic [61:0] sq_prod;
    logic [63:0] rb_sum;
    logic [64:0] mag_scaled;
    logic [64:0] mag;
    logic [65:0] total_sum;

    always_comb begin
        sq_op      = (r_state == ST_SQ_A) ? r_a[30:0] : r_b[30:0];
        sq_prod    = {31'b0, sq_op} * {31'b0, sq_op};
        rb_sum     = r_res + r_bit;
        mag_scaled = ({33'b0, r_res[31:0]} << r_shift) + 65'd16384;
        mag        = mag_scaled >> 15;
        total_sum  = {18'b0, r_total} + {1'b0, mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else begin
            if (r_state == ST_IDLE) begin
                r_total <= '0;
            end
            if (r_state == ST_MAC && mac_done) begin
                r_a     <= r_re[63] ? 64'(-r_re) : 64'(r_re);
                r_b     <= r_im[63] ? 64'(-r_im) : 64'(r_im);
                r_shift <= '0;
            end
            if (r_state == ST_SHIFT && !shift_done) begin
                r_a     <= r_a >> 1;
                r_b     <= r_b >> 1;
                r_shift <= r_shift + 1'b1;
            end
            if (r_state == ST_SQ_A) begin
                r_v <= {2'b0, sq_prod};
            end
            if (r_state == ST_SQ_B) begin
                r_v      <= r_v + {2'b0, sq_prod};
                r_res    <= '0;
                r_bit    <= 64'd1 << 62;
                r_sq_cnt <= '0;
            end
            if (r_state == ST_SQRT) begin
                if (r_v >= rb_sum) begin
                    r_v   <= r_v - rb_sum;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit    <= r_bit >> 2;
                r_sq_cnt <= r_sq_cnt + 1'b1;
            end
            if (r_state == ST_ACC) begin
                r_total <= (total_sum > {18'b0, SAT48}) ? SAT48 : total_sum[47:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // EMA: four partial products through one 17 x 24 multiplier.
    // ------------------------------------------------------------------------
    logic [16:0] ema_coef;
    logic [23:0] ema_data;
    logic [40:0] ema_prod;
    logic [65:0] ema_term;
    logic [65:0] ema_round;

    always_comb begin
        ema_coef = r_ema_step[1] ? EMA_WC : EMA_W;
        unique case (r_ema_step)
            2'd0:    ema_data = r_total[23:0];
            2'd1:    ema_data = r_total[47:24];
            2'd2:    ema_data = r_ema[23:0];
            default: ema_data = r_ema[47:24];
        endcase
        ema_prod  = {24'b0, ema_coef} * {17'b0, ema_data};
        ema_term  = r_ema_step[0] ? ({25'b0, ema_prod} << 24) : {25'b0, ema_prod};
        ema_round = (r_ema_acc + 66'd32768) >> 16;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema         <= '0;
            r_ema_started <= 1'b0;
            r_ema_step    <= '0;
        end else begin
            if (r_state == ST_EMA) begin
                if (!r_ema_started) begin
                    r_ema         <= r_total;
                    r_ema_started <= 1'b1;
                end else begin
                    r_ema_acc  <= ((r_ema_step == 2'd0) ? '0 : r_ema_acc) + ema_term;
                    r_ema_step <= r_ema_step + 1'b1;
                end
            end
            if (r_state == ST_EMA_FIN) begin
                r_ema <= ema_round[47:0];
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc && (step_reject || !win_full)) begin
                r_out_vld       <= 1'b1;
                r_out_valid_res <= 1'b0;
                r_out_status    <= step_reject ? STATUS_REJECT : STATUS_FILLING;
                r_out_degree    <= r_ema;
            end else if (r_state == ST_DONE && out_free) begin
                r_out_vld       <= 1'b1;
                r_out_valid_res <= r_ema <= r_degree_limit;
                r_out_status    <= STATUS_SPECTRUM;
                r_out_degree    <= r_ema;
            end else if (out_take) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_valid     = r_out_vld;
    assign o_valid_res = r_out_valid_res;
    assign o_status    = r_out_status;
    assign o_degree    = r_out_degree;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(WINDOW_SIZE))
        else $error("window fill count beyond window size");

    a_pipe_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p1_vld || r_p2_vld) |-> (r_state == ST_MAC || r_state == ST_SHIFT))
        else $error("multiply pipeline active outside a bin");

    a_reject_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && step_reject) |=> (o_valid && o_status == STATUS_REJECT))
        else $error("rejected sample gave no reject result");

    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT) |-> $onehot(r_bit))
        else $error("root trial bit lost");

    a_spectrum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_DONE) |=> $stable(r_last_height))
        else $error("last height changed during a spectrum");

endmodule
